// ----- rtl/nearest_neighbor_scale_address_top_assert.svh -----
// Assertion helpers for the scaler address generator.
// Every user module has clk and rst_n in scope.
`ifndef NEAREST_NEIGHBOR_SCALE_ADDRESS_TOP_ASSERT_SVH
`define NEAREST_NEIGHBOR_SCALE_ADDRESS_TOP_ASSERT_SVH

// Check a property in the same cycle as its trigger.
`define NNSA_ASSERT_NOW(label, trig, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
        else $error("nnsa assertion failed");

// Check a property in the cycle after its trigger.
`define NNSA_ASSERT_NEXT(label, trig, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error("nnsa assertion failed");

`endif

// ----- rtl/nnsa_pkg.sv -----
package nnsa_pkg;

    // Field widths
    localparam int CFG_W    = 13;
    localparam int IDX_W    = 12;
    localparam int ADDR_W   = 24;
    localparam int SHIFT_W  = 12;
    localparam int REGSEL_W = 3;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef enum logic [REGSEL_W-1:0] {
        REG_SOURCE_WIDTH  = 3'd0,
        REG_SOURCE_HEIGHT = 3'd1,
        REG_TARGET_WIDTH  = 3'd2,
        REG_TARGET_HEIGHT = 3'd3,
        REG_SCALE_MODE    = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        MODE_FIT  = 1'b0,
        MODE_FILL = 1'b1
    } mode_t;

    typedef enum logic {
        SEL_ROW    = 1'b0,
        SEL_COLUMN = 1'b1
    } ratio_sel_t;

    typedef enum logic [1:0] {
        DRV_IDLE    = 2'd0,
        DRV_PRODUCT = 2'd1,
        DRV_GO      = 2'd2,
        DRV_WAIT    = 2'd3
    } drv_state_t;

    typedef enum logic [1:0] {
        OP_ROW    = 2'd0,
        OP_COLUMN = 2'd1,
        OP_EXTENT = 2'd2,
        OP_SHIFT  = 2'd3
    } div_op_t;

    // Derived scaling setup handed from the configuration unit to the datapath
    typedef struct packed {
        logic               ready;
        logic [CFG_W-1:0]   sw;
        logic [CFG_W-1:0]   sh;
        logic [CFG_W-1:0]   tw;
        logic [CFG_W-1:0]   th;
        mode_t              mode;
        logic               fit_to_height;
        logic [CFG_W-1:0]   active_extent;
        logic [SHIFT_W-1:0] centring_shift;
    } settings_t;

    // One classified word in the queue
    typedef struct packed {
        logic              hit;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        ratio_sel_t        rsel;
        ratio_sel_t        csel;
        logic [ADDR_W-1:0] taddr;
    } item_t;

endpackage

// ----- rtl/nnsa_div.sv -----
module nnsa_div #(
    parameter int NUM_W = 29
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [NUM_W-1:0]          num,
    input  logic [nnsa_pkg::CFG_W-1:0] den,
    output logic                      busy,
    output logic                      done,
    output logic [NUM_W-1:0]          quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [nnsa_pkg::CFG_W-1:0] rem_reg, rem_next;
    logic [nnsa_pkg::CFG_W-1:0] den_reg, den_next;
    logic [NUM_W-1:0]           quo_reg, quo_next;
    logic [nnsa_pkg::CFG_W:0]   rem_shift;
    logic [nnsa_pkg::CFG_W:0]   rem_diff;
    logic                       fits;

    // One restoring step: bring down the next numerator bit
    assign rem_shift = {rem_reg, quo_reg[NUM_W-1]};
    assign fits      = rem_shift >= {1'b0, den_reg};
    assign rem_diff  = rem_shift - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            rem_next  = '0;
            den_next  = den;
            quo_next  = num;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? rem_diff[nnsa_pkg::CFG_W-1:0] : rem_shift[nnsa_pkg::CFG_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operands and partial result
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ----- rtl/nnsa_cfg.sv -----
`include "nearest_neighbor_scale_address_top_assert.svh"

module nnsa_cfg #(
    parameter int MAX_DIMENSION = 4096,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [nnsa_pkg::REGSEL_W-1:0]          cfg_index,
    input  logic [nnsa_pkg::CFG_W-1:0]             cfg_data,
    output nnsa_pkg::settings_t                    settings,
    output logic [FRACTION_BITS+nnsa_pkg::IDX_W-1:0] ratio_row,
    output logic [FRACTION_BITS+nnsa_pkg::IDX_W-1:0] ratio_column
);

    localparam int CFG_W   = nnsa_pkg::CFG_W;
    localparam int RATIO_W = FRACTION_BITS + nnsa_pkg::IDX_W;
    localparam int PROD_W  = 2 * CFG_W;
    localparam int NUM_W   = (FRACTION_BITS + CFG_W > PROD_W + 1) ?
                             (FRACTION_BITS + CFG_W) : (PROD_W + 1);

    logic [CFG_W-1:0]     src_w_reg, src_h_reg, tgt_w_reg, tgt_h_reg;
    nnsa_pkg::mode_t      mode_reg;
    nnsa_pkg::drv_state_t state_reg, state_next;
    nnsa_pkg::div_op_t    op_reg, op_next;
    logic [PROD_W-1:0]    prod_a_reg, prod_a_next;
    logic [PROD_W-1:0]    prod_b_reg, prod_b_next;
    logic                 fit_h_reg;
    logic [RATIO_W-1:0]   ratio_row_reg, ratio_col_reg, ratio_sat;
    logic [CFG_W-1:0]     extent_reg;
    logic [nnsa_pkg::SHIFT_W-1:0] shift_reg;
    logic [CFG_W-1:0]     sw, sh, tw, th;
    logic                 cfg_wr;
    logic                 div_start, div_busy, div_done;
    logic [NUM_W-1:0]     div_num, div_quo;
    logic [CFG_W-1:0]     div_den;

    // Map zero to one and clip to the largest supported dimension
    function automatic logic [CFG_W-1:0] dim_of(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] d;
        if (v == '0)
            d = CFG_W'(1);
        else if (int'(v) > MAX_DIMENSION)
            d = CFG_W'(MAX_DIMENSION);
        else
            d = v;
        return d;
    endfunction

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid;

    assign sw = dim_of(src_w_reg);
    assign sh = dim_of(src_h_reg);
    assign tw = dim_of(tgt_w_reg);
    assign th = dim_of(tgt_h_reg);

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= CFG_W'(640);
            src_h_reg <= CFG_W'(480);
            tgt_w_reg <= CFG_W'(640);
            tgt_h_reg <= CFG_W'(480);
            mode_reg  <= nnsa_pkg::MODE_FIT;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                nnsa_pkg::REG_SOURCE_WIDTH:  src_w_reg <= cfg_data;
                nnsa_pkg::REG_SOURCE_HEIGHT: src_h_reg <= cfg_data;
                nnsa_pkg::REG_TARGET_WIDTH:  tgt_w_reg <= cfg_data;
                nnsa_pkg::REG_TARGET_HEIGHT: tgt_h_reg <= cfg_data;
                nnsa_pkg::REG_SCALE_MODE:    mode_reg  <= nnsa_pkg::mode_t'(cfg_data[0]);
                default: ;
            endcase
        end
    end

    // Derivation sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        if (cfg_wr)
        begin
            state_next = nnsa_pkg::DRV_PRODUCT;
        end
        else
        begin
            case (state_reg)
                nnsa_pkg::DRV_PRODUCT:
                begin
                    state_next = nnsa_pkg::DRV_GO;
                    op_next    = nnsa_pkg::OP_ROW;
                end
                nnsa_pkg::DRV_GO:
                begin
                    state_next = nnsa_pkg::DRV_WAIT;
                end
                nnsa_pkg::DRV_WAIT:
                begin
                    if (div_done)
                    begin
                        if (op_reg == nnsa_pkg::OP_SHIFT)
                        begin
                            state_next = nnsa_pkg::DRV_IDLE;
                        end
                        else
                        begin
                            state_next = nnsa_pkg::DRV_GO;
                            op_next    = nnsa_pkg::div_op_t'(op_reg + 2'd1);
                        end
                    end
                end
                nnsa_pkg::DRV_IDLE: ;
                default: state_next = nnsa_pkg::DRV_PRODUCT;
            endcase
        end
    end

    // Derivation sequencer: divider operands
    always_comb
    begin
        div_start = (state_reg == nnsa_pkg::DRV_GO);
        div_num   = '0;
        div_den   = CFG_W'(1);
        case (op_reg)
            nnsa_pkg::OP_ROW:
            begin
                div_num = NUM_W'(sh) << FRACTION_BITS;
                div_den = th;
            end
            nnsa_pkg::OP_COLUMN:
            begin
                div_num = NUM_W'(sw) << FRACTION_BITS;
                div_den = tw;
            end
            nnsa_pkg::OP_EXTENT:
            begin
                // Round up: add divisor minus one
                div_num = fit_h_reg ? NUM_W'(prod_a_reg) + NUM_W'(sh) - NUM_W'(1)
                                    : NUM_W'(prod_b_reg) + NUM_W'(sw) - NUM_W'(1);
                div_den = fit_h_reg ? sh : sw;
            end
            nnsa_pkg::OP_SHIFT:
            begin
                // Halve the quotient afterwards
                div_num = fit_h_reg ? NUM_W'(prod_b_reg - prod_a_reg)
                                    : NUM_W'(prod_a_reg - prod_b_reg);
                div_den = fit_h_reg ? sh : sw;
            end
            default: ;
        endcase
    end

    assign prod_a_next = PROD_W'(sw) * PROD_W'(th);
    assign prod_b_next = PROD_W'(sh) * PROD_W'(tw);
    assign ratio_sat   = (div_quo[NUM_W-1:RATIO_W] != '0) ? '1 : div_quo[RATIO_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nnsa_pkg::DRV_PRODUCT;
            op_reg    <= nnsa_pkg::OP_ROW;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    // Capture cross products and division results
    always_ff @(posedge clk)
    begin
        if (state_reg == nnsa_pkg::DRV_PRODUCT)
        begin
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
        end
        if (state_reg == nnsa_pkg::DRV_GO)
        begin
            fit_h_reg <= !(prod_a_reg > prod_b_reg);
        end
        if ((state_reg == nnsa_pkg::DRV_WAIT) && div_done)
        begin
            case (op_reg)
                nnsa_pkg::OP_ROW:    ratio_row_reg <= ratio_sat;
                nnsa_pkg::OP_COLUMN: ratio_col_reg <= ratio_sat;
                nnsa_pkg::OP_EXTENT: extent_reg    <= div_quo[CFG_W-1:0];
                nnsa_pkg::OP_SHIFT:  shift_reg     <= div_quo[nnsa_pkg::SHIFT_W:1];
                default: ;
            endcase
        end
    end

    nnsa_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        settings.ready          = (state_reg == nnsa_pkg::DRV_IDLE);
        settings.sw             = sw;
        settings.sh             = sh;
        settings.tw             = tw;
        settings.th             = th;
        settings.mode           = mode_reg;
        settings.fit_to_height  = fit_h_reg;
        settings.active_extent  = extent_reg;
        settings.centring_shift = shift_reg;
    end

    assign ratio_row    = ratio_row_reg;
    assign ratio_column = ratio_col_reg;

    // The divider is quiet whenever the setup is reported complete
    `NNSA_ASSERT_NOW(a_idle_div_quiet, state_reg == nnsa_pkg::DRV_IDLE, !div_busy)

endmodule

// ----- rtl/nnsa_front.sv -----
module nnsa_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [nnsa_pkg::IDX_W-1:0]   row_index,
    input  logic [nnsa_pkg::IDX_W-1:0]   column_index,
    input  nnsa_pkg::settings_t          settings,
    input  logic                         full,
    output logic                         push,
    output nnsa_pkg::item_t              entry
);

    localparam int CFG_W = nnsa_pkg::CFG_W;
    localparam int TA_W  = 2 * CFG_W + 1;

    logic                        f_valid_reg, f_valid_next;
    logic                        hit_reg, hit_next;
    logic [nnsa_pkg::IDX_W-1:0]  row_reg, col_reg;
    nnsa_pkg::ratio_sel_t        rsel_reg, rsel_next;
    nnsa_pkg::ratio_sel_t        csel_reg, csel_next;
    logic [CFG_W-1:0]            row_off_reg, row_off_next;
    logic [CFG_W-1:0]            col_off_reg, col_off_next;
    logic [CFG_W-1:0]            row_w, col_w;
    logic [TA_W-1:0]             taddr_full;
    logic                        accept;

    assign in_ready = settings.ready && (!f_valid_reg || !full);
    assign accept   = in_valid && in_ready;
    assign push     = f_valid_reg && !full;

    assign row_w = CFG_W'(row_index);
    assign col_w = CFG_W'(column_index);

    // Classify the position against the active region
    always_comb
    begin
        hit_next     = 1'b0;
        rsel_next    = nnsa_pkg::SEL_ROW;
        csel_next    = nnsa_pkg::SEL_COLUMN;
        row_off_next = row_w;
        col_off_next = col_w;
        case (settings.mode)
            nnsa_pkg::MODE_FILL:
            begin
                hit_next = (row_w < settings.th) && (col_w < settings.tw);
            end
            nnsa_pkg::MODE_FIT:
            begin
                if (settings.fit_to_height)
                begin
                    hit_next     = (row_w < settings.th) && (col_w < settings.active_extent);
                    csel_next    = nnsa_pkg::SEL_ROW;
                    col_off_next = col_w + CFG_W'(settings.centring_shift);
                end
                else
                begin
                    hit_next     = (row_w < settings.active_extent) && (col_w < settings.tw);
                    rsel_next    = nnsa_pkg::SEL_COLUMN;
                    row_off_next = row_w + CFG_W'(settings.centring_shift);
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        f_valid_next = f_valid_reg;
        if (accept)
            f_valid_next = 1'b1;
        else if (push)
            f_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else
            f_valid_reg <= f_valid_next;
    end

    // Hold the classified word until the queue takes it
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg     <= hit_next;
            row_reg     <= row_index;
            col_reg     <= column_index;
            rsel_reg    <= rsel_next;
            csel_reg    <= csel_next;
            row_off_reg <= row_off_next;
            col_off_reg <= col_off_next;
        end
    end

    // Linear destination index with the centring offset folded in
    assign taddr_full = TA_W'(row_off_reg) * TA_W'(settings.tw) + TA_W'(col_off_reg);

    always_comb
    begin
        entry.hit   = hit_reg;
        entry.row   = row_reg;
        entry.col   = col_reg;
        entry.rsel  = rsel_reg;
        entry.csel  = csel_reg;
        entry.taddr = taddr_full[nnsa_pkg::ADDR_W-1:0];
    end

endmodule

// ----- rtl/nnsa_queue.sv -----
`include "nearest_neighbor_scale_address_top_assert.svh"

module nnsa_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  nnsa_pkg::item_t wr_item,
    output logic            full,
    input  logic            pop,
    output nnsa_pkg::item_t rd_item,
    output logic            empty
);

    localparam int QPTR_W = nnsa_pkg::QPTR_W;
    localparam int QCNT_W = nnsa_pkg::QCNT_W;

    nnsa_pkg::item_t   slot_reg [nnsa_pkg::QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == QCNT_W'(nnsa_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_item = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming word
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_item;
    end

    `NNSA_ASSERT_NOW(a_queue_bound, 1'b1, count_reg <= QCNT_W'(nnsa_pkg::QUEUE_DEPTH))
    `NNSA_ASSERT_NOW(a_pop_has_word, pop, count_reg != '0)

endmodule

// ----- rtl/nnsa_back.sv -----
module nnsa_back #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     empty,
    output logic                                     pop,
    input  nnsa_pkg::item_t                          head,
    input  nnsa_pkg::settings_t                      settings,
    input  logic [FRACTION_BITS+nnsa_pkg::IDX_W-1:0] ratio_row,
    input  logic [FRACTION_BITS+nnsa_pkg::IDX_W-1:0] ratio_column,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic                                     write_valid,
    output logic [nnsa_pkg::ADDR_W-1:0]              target_address,
    output logic [nnsa_pkg::ADDR_W-1:0]              source_address
);

    localparam int CFG_W   = nnsa_pkg::CFG_W;
    localparam int ADDR_W  = nnsa_pkg::ADDR_W;
    localparam int RATIO_W = FRACTION_BITS + nnsa_pkg::IDX_W;
    localparam int MUL_W   = nnsa_pkg::IDX_W + RATIO_W;
    localparam int COORD_W = 2 * nnsa_pkg::IDX_W;
    localparam int SA_W    = 2 * CFG_W + 1;

    logic                 adv;
    logic [RATIO_W-1:0]   rratio, cratio;
    logic [MUL_W-1:0]     prod_r, prod_c;

    logic                 s1_valid_reg, s1_valid_next;
    logic                 s1_hit_reg;
    logic [ADDR_W-1:0]    s1_taddr_reg;
    logic [COORD_W-1:0]   s1_crow_reg, s1_crow_next;
    logic [COORD_W-1:0]   s1_ccol_reg, s1_ccol_next;

    logic                 s2_valid_reg;
    logic                 s2_hit_reg;
    logic [ADDR_W-1:0]    s2_taddr_reg;
    logic [CFG_W-1:0]     s2_srow_reg, s2_srow_next;
    logic [CFG_W-1:0]     s2_scol_reg, s2_scol_next;

    logic                 out_valid_reg;
    logic                 wv_reg;
    logic [ADDR_W-1:0]    ta_reg, ta_next;
    logic [ADDR_W-1:0]    sa_reg, sa_next;
    logic [SA_W-1:0]      sa_full;

    // Whole pipe moves unless a finished word is stalled at the output
    assign adv = !out_valid_reg || out_ready;
    assign pop = adv && !empty;

    // Stage 1: scale the indices into source coordinates
    assign rratio = (head.rsel == nnsa_pkg::SEL_ROW) ? ratio_row : ratio_column;
    assign cratio = (head.csel == nnsa_pkg::SEL_ROW) ? ratio_row : ratio_column;
    assign prod_r = MUL_W'(head.row) * MUL_W'(rratio);
    assign prod_c = MUL_W'(head.col) * MUL_W'(cratio);
    assign s1_crow_next  = prod_r[FRACTION_BITS +: COORD_W];
    assign s1_ccol_next  = prod_c[FRACTION_BITS +: COORD_W];
    assign s1_valid_next = pop;

    // Stage 2: clamp to the last source row and column
    assign s2_srow_next = (s1_crow_reg >= COORD_W'(settings.sh)) ?
                          (settings.sh - CFG_W'(1)) : s1_crow_reg[CFG_W-1:0];
    assign s2_scol_next = (s1_ccol_reg >= COORD_W'(settings.sw)) ?
                          (settings.sw - CFG_W'(1)) : s1_ccol_reg[CFG_W-1:0];

    // Stage 3: linear source index, zero both addresses outside the region
    assign sa_full = SA_W'(s2_srow_reg) * SA_W'(settings.sw) + SA_W'(s2_scol_reg);
    assign sa_next = s2_hit_reg ? sa_full[ADDR_W-1:0] : '0;
    assign ta_next = s2_hit_reg ? s2_taddr_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_hit_reg   <= head.hit;
            s1_taddr_reg <= head.taddr;
            s1_crow_reg  <= s1_crow_next;
            s1_ccol_reg  <= s1_ccol_next;
            s2_hit_reg   <= s1_hit_reg;
            s2_taddr_reg <= s1_taddr_reg;
            s2_srow_reg  <= s2_srow_next;
            s2_scol_reg  <= s2_scol_next;
            wv_reg       <= s2_hit_reg;
            ta_reg       <= ta_next;
            sa_reg       <= sa_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign write_valid    = wv_reg;
    assign target_address = ta_reg;
    assign source_address = sa_reg;

endmodule

// ----- rtl/nearest_neighbor_scale_address_top.sv -----
// Nearest-neighbor scaler address generator.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets source and
// target sizes and the scale mode; it is always ready. Write it only while
// no words are in flight. Each write starts a new setup pass.
// Input channel (in_valid/in_ready) takes one word of row_index and
// column_index; output channel (out_valid/out_ready) returns write_valid,
// target_address and source_address for it, in order.
// Throughput: one word per cycle unless the output stalls or a setup pass runs.
// Each word passes through the front register, the queue and the back pipeline.
// Setup pass: one shared radix-2 divider computes both scale ratios, the
// active extent and the centring shift in turn, on an N-bit numerator with
// N = max(FRACTION_BITS + 13, 27), 29 at the defaults. in_ready
// stays low through the pass, which also runs right after reset.
// When the receiver stalls, the output word holds, the back pipeline holds
// and a 4-word queue plus the front register keep taking input until full.
// Reset (rst_n, asynchronous, active low) restores 640x480 to 640x480 in
// fit mode and empties the pipeline.
`include "nearest_neighbor_scale_address_top_assert.svh"

module nearest_neighbor_scale_address_top #(
    parameter int MAX_DIMENSION = 4096,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [nnsa_pkg::REGSEL_W-1:0]       cfg_index,
    input  logic [nnsa_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [nnsa_pkg::IDX_W-1:0]          row_index,
    input  logic [nnsa_pkg::IDX_W-1:0]          column_index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                write_valid,
    output logic [nnsa_pkg::ADDR_W-1:0]         target_address,
    output logic [nnsa_pkg::ADDR_W-1:0]         source_address
);

    localparam int RATIO_W = FRACTION_BITS + nnsa_pkg::IDX_W;

    nnsa_pkg::settings_t settings;
    logic [RATIO_W-1:0]  ratio_row, ratio_column;
    logic                push, full, pop, empty;
    nnsa_pkg::item_t     entry, head;

    nnsa_cfg #(
        .MAX_DIMENSION (MAX_DIMENSION),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .settings     (settings),
        .ratio_row    (ratio_row),
        .ratio_column (ratio_column)
    );

    nnsa_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .row_index    (row_index),
        .column_index (column_index),
        .settings     (settings),
        .full         (full),
        .push         (push),
        .entry        (entry)
    );

    nnsa_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_item (entry),
        .full    (full),
        .pop     (pop),
        .rd_item (head),
        .empty   (empty)
    );

    nnsa_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .empty          (empty),
        .pop            (pop),
        .head           (head),
        .settings       (settings),
        .ratio_row      (ratio_row),
        .ratio_column   (ratio_column),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .write_valid    (write_valid),
        .target_address (target_address),
        .source_address (source_address)
    );

    // Positions outside the active region report no addresses
    `NNSA_ASSERT_NOW(a_miss_zero, out_valid && !write_valid, (target_address == '0) && (source_address == '0))
    // A config write holds off input while the setup is recomputed
    `NNSA_ASSERT_NEXT(a_cfg_blocks_input, cfg_valid && cfg_ready, !in_ready)

endmodule
